FILE: src/shsvd_pkg.sv
// ----------------------------------------------------------------------------
// Half-step stepper driver package
// Shared widths, codes, register reset values, item types and the half-step
// coil table.
// ----------------------------------------------------------------------------
package shsvd_pkg;

  localparam int COUNTER_BITS_DEF  = 20;
  localparam int VELOCITY_BITS_DEF = 32;

  localparam int THR_W      = 40;
  localparam int MINSPD_W   = 31;
  localparam int HOLD_W     = 20;
  localparam int PERIOD_W   = 20;
  localparam int POS_W      = 32;
  localparam int ACCEL_W    = 21;
  localparam int COIL_W     = 4;
  localparam int VEL_OUT_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_THRESHOLD = 3'd0,
    REG_MIN_SPEED      = 3'd1,
    REG_HOLD_TIMEOUT   = 3'd2,
    REG_UPDATE_PERIOD  = 3'd3,
    REG_POSITION_LIMIT = 3'd4
  } reg_index_t;

  typedef enum logic {
    OP_TICK      = 1'b0,
    OP_SET_ACCEL = 1'b1
  } op_t;

  typedef struct packed {
    logic [THR_W-1:0]        step_threshold;
    logic [MINSPD_W-1:0]     min_speed;
    logic [HOLD_W-1:0]       hold_timeout;
    logic [PERIOD_W-1:0]     update_period;
    logic signed [POS_W-1:0] position_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    step_threshold: 40'd250000000,
    min_speed:      31'd1000,
    hold_timeout:   20'd50000,
    update_period:  20'd1000,
    position_limit: -32'sd1900
  };

  typedef struct packed {
    logic                      operation;
    logic signed [ACCEL_W-1:0] accel_value;
    logic                      stop_switch;
  } in_item_t;

  typedef struct packed {
    logic [COIL_W-1:0]           coil_pattern;
    logic                        step_taken;
    logic signed [POS_W-1:0]     position_now;
    logic signed [VEL_OUT_W-1:0] velocity_now;
  } out_item_t;

  function automatic logic [COIL_W-1:0] half_step_coils(input logic [2:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

FILE: src/shsvd_in_if.sv
// ----------------------------------------------------------------------------
// Half-step stepper driver input channel
// Valid/ready channel carrying one tick or acceleration request.
// ----------------------------------------------------------------------------
interface shsvd_in_if;
  import shsvd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [ACCEL_W-1:0] accel_value;
  logic                      stop_switch;

  modport source(output valid, operation, accel_value, stop_switch, input ready);
  modport sink(input valid, operation, accel_value, stop_switch, output ready);
endinterface

FILE: src/shsvd_out_if.sv
// ----------------------------------------------------------------------------
// Half-step stepper driver result channel
// Valid/ready channel carrying the coil drive, step flag, position and velocity.
// ----------------------------------------------------------------------------
interface shsvd_out_if;
  import shsvd_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [COIL_W-1:0]           coil_pattern;
  logic                        step_taken;
  logic signed [POS_W-1:0]     position_now;
  logic signed [VEL_OUT_W-1:0] velocity_now;

  modport source(output valid, coil_pattern, step_taken, position_now, velocity_now,
                 input ready);
  modport sink(input valid, coil_pattern, step_taken, position_now, velocity_now,
               output ready);
endinterface

FILE: src/shsvd_cfg_if.sv
// ----------------------------------------------------------------------------
// Half-step stepper driver configuration channel
// Valid/ready register write channel with register index and write data.
// ----------------------------------------------------------------------------
interface shsvd_cfg_if;
  import shsvd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/stepper_half_step_velocity_driver.sv
// ----------------------------------------------------------------------------
// Half-step stepper velocity driver
// Drives a four-coil stepper in half steps from a signed acceleration. One
// request is taken every clock cycle while the result is taken, each a
// one-microsecond tick or an acceleration write, and each gives exactly one
// result: it passes the input register, then the motion core into the result
// register. The rate of one request per cycle, when the output does not
// stall, is set by the step test, a multiply of the tick count by the speed
// compared against the step threshold, whose outcome feeds the motion state
// back for the next request. When the result is not taken, the input register
// holds and input ready falls. Configuration writes take effect on the next
// request processed.
// ----------------------------------------------------------------------------
module stepper_half_step_velocity_driver #(
  parameter int COUNTER_BITS  = shsvd_pkg::COUNTER_BITS_DEF,
  parameter int VELOCITY_BITS = shsvd_pkg::VELOCITY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  shsvd_in_if.sink    in_chan,
  shsvd_out_if.source out_chan,
  shsvd_cfg_if.sink   cfg_chan
);
  import shsvd_pkg::*;

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t res;
  cfg_t      cfg;
  logic      advance;
  logic      proc;
  logic      in_take;

  assign advance       = !out_vld_r || out_chan.ready;
  assign proc          = in_vld_r && advance;
  assign in_chan.ready = !in_vld_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  shsvd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  shsvd_core #(
    .COUNTER_BITS  (COUNTER_BITS),
    .VELOCITY_BITS (VELOCITY_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .proc_i (proc),
    .item_i (in_item_r),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (proc) begin
        in_vld_r <= 1'b0;
      end
      if (proc) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.operation   <= in_chan.operation;
      in_item_r.accel_value <= in_chan.accel_value;
      in_item_r.stop_switch <= in_chan.stop_switch;
    end
    if (proc) begin
      out_item_r <= res;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.coil_pattern = out_item_r.coil_pattern;
  assign out_chan.step_taken   = out_item_r.step_taken;
  assign out_chan.position_now = out_item_r.position_now;
  assign out_chan.velocity_now = out_item_r.velocity_now;

endmodule

FILE: src/shsvd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Half-step stepper driver configuration registers
// Holds the five control registers; writes are always accepted and registered.
// ----------------------------------------------------------------------------
module shsvd_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  shsvd_cfg_if.sink        cfg_chan,
  output shsvd_pkg::cfg_t  cfg_o
);
  import shsvd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg_o          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_STEP_THRESHOLD: cfg_nxt.step_threshold = cfg_chan.data[THR_W-1:0];
        REG_MIN_SPEED:      cfg_nxt.min_speed      = cfg_chan.data[MINSPD_W-1:0];
        REG_HOLD_TIMEOUT:   cfg_nxt.hold_timeout   = cfg_chan.data[HOLD_W-1:0];
        REG_UPDATE_PERIOD:  cfg_nxt.update_period  = cfg_chan.data[PERIOD_W-1:0];
        REG_POSITION_LIMIT: cfg_nxt.position_limit = $signed(cfg_chan.data[POS_W-1:0]);
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: src/shsvd_core.sv
// ----------------------------------------------------------------------------
// Half-step stepper driver motion core
// Motion state and the combinational update for one request: step test,
// velocity update, hold timeout and stop check.
// ----------------------------------------------------------------------------
module shsvd_core #(
  parameter int COUNTER_BITS  = shsvd_pkg::COUNTER_BITS_DEF,
  parameter int VELOCITY_BITS = shsvd_pkg::VELOCITY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc_i,
  input  shsvd_pkg::in_item_t  item_i,
  input  shsvd_pkg::cfg_t      cfg_i,
  output shsvd_pkg::out_item_t res_o
);
  import shsvd_pkg::*;

  localparam int SPD_W     = VELOCITY_BITS - 1;
  localparam int PROD_W    = COUNTER_BITS + SPD_W;
  localparam int THR_CMP_W = (PROD_W > THR_W) ? PROD_W : THR_W;
  localparam int SPD_CMP_W = (SPD_W > MINSPD_W) ? SPD_W : MINSPD_W;
  localparam int CNT_CMP_W = (COUNTER_BITS > HOLD_W) ? COUNTER_BITS : HOLD_W;
  localparam int SUM_W     = ((VELOCITY_BITS > ACCEL_W) ? VELOCITY_BITS : ACCEL_W) + 1;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);
  localparam logic signed [SUM_W-1:0] VMAX =
    SUM_W'((longint'(1) <<< (VELOCITY_BITS - 1)) - longint'(1));
  localparam logic signed [SUM_W-1:0] VMIN = -VMAX;
  localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MINUS1 = '1;

  // The tick and update counters hold the value the next tick will see,
  // so the step multiplier is fed straight from registers.
  logic signed [VELOCITY_BITS-1:0] vel_r, vel_nxt;
  logic [SPD_W-1:0]                spd_r, spd_nxt;
  logic [POS_W-1:0]                pos_r, pos_nxt;
  logic signed [ACCEL_W-1:0]       acc_r, acc_nxt;
  logic [COUNTER_BITS-1:0]         tick_cnt_r, tick_cnt_nxt;
  logic [COUNTER_BITS-1:0]         upd_cnt_r, upd_cnt_nxt;
  logic [COIL_W-1:0]               coil_r, coil_nxt;

  logic [PROD_W-1:0]       prod;
  logic                    is_tick;
  logic                    fast_enough;
  logic                    step;
  logic                    upd;
  logic                    hold_off;
  logic                    stop;
  logic [COUNTER_BITS-1:0] since_fin;
  logic [COUNTER_BITS-1:0] tick_cnt_inc;
  logic [COUNTER_BITS-1:0] upd_cnt_inc;
  logic signed [SUM_W-1:0] vsum;
  logic signed [SUM_W-1:0] vsat;
  logic [POS_W-1:0]        pos_step;

  assign is_tick     = (item_i.operation == OP_TICK);
  assign prod        = PROD_W'(tick_cnt_r) * PROD_W'(spd_r);
  assign fast_enough = SPD_CMP_W'(spd_r) > SPD_CMP_W'(cfg_i.min_speed);
  assign step        = is_tick && fast_enough &&
                       (THR_CMP_W'(prod) > THR_CMP_W'(cfg_i.step_threshold));

  assign tick_cnt_inc = (tick_cnt_r == CNT_MAX) ? tick_cnt_r : tick_cnt_r + CNT_ONE;
  assign upd_cnt_inc  = (upd_cnt_r == CNT_MAX) ? upd_cnt_r : upd_cnt_r + CNT_ONE;
  assign since_fin    = step ? '0 : tick_cnt_r;

  assign upd      = is_tick && (CNT_CMP_W'(upd_cnt_r) >= CNT_CMP_W'(cfg_i.update_period));
  assign hold_off = CNT_CMP_W'(since_fin) > CNT_CMP_W'(cfg_i.hold_timeout);

  assign vsum = SUM_W'(vel_r) + SUM_W'(acc_r);
  assign vsat = (vsum > VMAX) ? VMAX : ((vsum < VMIN) ? VMIN : vsum);

  assign pos_step = step ? (pos_r + ((vel_r > 0) ? POS_ONE : POS_MINUS1)) : pos_r;
  assign stop     = item_i.stop_switch || ($signed(pos_step) < $signed(cfg_i.position_limit));

  always_comb begin
    vel_nxt      = vel_r;
    acc_nxt      = acc_r;
    tick_cnt_nxt = tick_cnt_r;
    upd_cnt_nxt  = upd_cnt_r;
    coil_nxt     = coil_r;
    pos_nxt      = pos_step;
    if (is_tick) begin
      tick_cnt_nxt = step ? CNT_ONE : tick_cnt_inc;
      upd_cnt_nxt  = upd ? CNT_ONE : upd_cnt_inc;
      if (step) begin
        coil_nxt = half_step_coils(pos_r[2:0]);
      end
      if (upd) begin
        vel_nxt = VELOCITY_BITS'(vsat);
      end
      if (hold_off) begin
        coil_nxt = '0;
      end
    end else begin
      acc_nxt = item_i.accel_value;
    end
    if (stop) begin
      vel_nxt = '0;
      acc_nxt = '0;
    end
    spd_nxt = vel_nxt[VELOCITY_BITS-1] ? SPD_W'(-vel_nxt) : SPD_W'(vel_nxt);
  end

  assign res_o.coil_pattern = coil_nxt;
  assign res_o.step_taken   = step;
  assign res_o.position_now = $signed(pos_nxt);
  assign res_o.velocity_now = VEL_OUT_W'(vel_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r      <= '0;
      spd_r      <= '0;
      pos_r      <= '0;
      acc_r      <= '0;
      tick_cnt_r <= CNT_ONE;
      upd_cnt_r  <= CNT_ONE;
      coil_r     <= '0;
    end else if (proc_i) begin
      vel_r      <= vel_nxt;
      spd_r      <= spd_nxt;
      pos_r      <= pos_nxt;
      acc_r      <= acc_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      upd_cnt_r  <= upd_cnt_nxt;
      coil_r     <= coil_nxt;
    end
  end

  a_speed_matches_velocity: assert property (@(posedge clk) disable iff (!rst_n)
    spd_r == SPD_W'((vel_r < 0) ? -vel_r : vel_r))
    else $error("speed register differs from velocity magnitude");

  a_counters_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_cnt_r != '0) && (upd_cnt_r != '0))
    else $error("look-ahead counter holds zero");

  a_step_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
    proc_i && step |=> ((pos_r - $past(pos_r)) == POS_ONE) ||
                       ((pos_r - $past(pos_r)) == POS_MINUS1))
    else $error("step did not move position by one");

  a_accel_write_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    proc_i && !is_tick |=> $stable(pos_r) && $stable(coil_r) && $stable(tick_cnt_r))
    else $error("acceleration request changed motion state");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc_i && item_i.stop_switch |=> (vel_r == '0) && (acc_r == '0) && (spd_r == '0))
    else $error("stop switch did not clear velocity and acceleration");

endmodule
